>>> rtl/core/script_lexer_tokenizer_macros.svh
// assertion helpers used by the checker file
`ifndef SCRIPT_LEXER_TOKENIZER_MACROS_SVH
`define SCRIPT_LEXER_TOKENIZER_MACROS_SVH

// property checked on every clock edge outside reset
`define SLT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define SLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/slt_pkg.sv
package slt_pkg;

    // fixed widths of the token fields
    localparam int OUT_W   = 16;
    localparam int KIND_W  = 6;
    localparam int MAX_TOK = 4;
    localparam int CNT_W   = 3;
    localparam int WORD_W  = 48;
    localparam int WLEN_W  = 3;
    localparam int NUM_KW  = 16;

    localparam logic [OUT_W-1:0]  OUT_MAX  = '1;
    localparam logic [WLEN_W-1:0] WLEN_MAX = '1;

    // lexer modes
    typedef enum logic [3:0] {
        M_IDLE,
        M_OP,
        M_SLASH,
        M_COMMENT,
        M_STRING,
        M_INT,
        M_NUMDOT,
        M_FRAC,
        M_IDENT
    } t_mode;

    // pending one-or-two-character operator
    typedef enum logic [2:0] {
        OP_NONE,
        OP_BANG,
        OP_EQUAL,
        OP_GREATER,
        OP_LESS
    } t_op;

    // token kinds
    localparam logic [KIND_W-1:0] K_LPAREN = 6'd0;
    localparam logic [KIND_W-1:0] K_RPAREN = 6'd1;
    localparam logic [KIND_W-1:0] K_LBRACE = 6'd2;
    localparam logic [KIND_W-1:0] K_RBRACE = 6'd3;
    localparam logic [KIND_W-1:0] K_COMMA  = 6'd4;
    localparam logic [KIND_W-1:0] K_DOT    = 6'd5;
    localparam logic [KIND_W-1:0] K_MINUS  = 6'd6;
    localparam logic [KIND_W-1:0] K_PLUS   = 6'd7;
    localparam logic [KIND_W-1:0] K_SEMI   = 6'd8;
    localparam logic [KIND_W-1:0] K_SLASH  = 6'd9;
    localparam logic [KIND_W-1:0] K_STAR   = 6'd10;
    localparam logic [KIND_W-1:0] K_STRING = 6'd19;
    localparam logic [KIND_W-1:0] K_NUMBER = 6'd20;
    localparam logic [KIND_W-1:0] K_IDENT  = 6'd21;
    localparam logic [KIND_W-1:0] K_KEY0   = 6'd22;
    localparam logic [KIND_W-1:0] K_END    = 6'd38;

    // character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // keyword text, first byte highest, and keyword lengths
    localparam logic [WORD_W-1:0] KW_TEXT [NUM_KW] = '{
        "and", "class", "else", "false", "fun", "for", "if", "nil",
        "or", "print", "return", "super", "this", "true", "var", "while"
    };
    localparam logic [WLEN_W-1:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
        3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
    };

    // channel payloads
    typedef struct packed {
        logic [7:0] char_byte;
        logic       byte_valid;
        logic       end_of_source;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [OUT_W-1:0]  token_start;
        logic [OUT_W-1:0]  token_length;
        logic [OUT_W-1:0]  token_line;
        logic              last_of_run;
    } t_token;

    // one token of a group, before the run marker is added
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OUT_W-1:0]  start;
        logic [OUT_W-1:0]  length;
        logic [OUT_W-1:0]  line;
    } t_tok_info;

    // tokens caused by one input item
    typedef struct packed {
        logic [CNT_W-1:0]               count;
        t_tok_info [MAX_TOK-1:0]        tok;
    } t_bundle;

    // decode of a byte seen with no lexeme open
    typedef struct packed {
        logic              emit;
        logic [KIND_W-1:0] kind;
        t_mode             mode;
        t_op               op;
        logic              newline;
        logic              letter;
    } t_fresh;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

    // keyword match over the stored word, identifier otherwise
    function automatic logic [KIND_W-1:0] word_kind(input logic [WORD_W-1:0] word,
                                                    input logic [WLEN_W-1:0] wlen);
        logic [KIND_W-1:0] kind;
        kind = K_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            if ((wlen == KW_LEN[k]) && (word == KW_TEXT[k])) begin
                kind = K_KEY0 + KIND_W'(k);
            end
        end
        return kind;
    endfunction

    function automatic t_fresh fresh_scan(input logic [7:0] c);
        t_fresh f;
        f.emit    = 1'b0;
        f.kind    = K_LPAREN;
        f.mode    = M_IDLE;
        f.op      = OP_NONE;
        f.newline = 1'b0;
        f.letter  = 1'b0;
        unique case (c)
            CH_LPAREN:  begin f.emit = 1'b1; f.kind = K_LPAREN; end
            CH_RPAREN:  begin f.emit = 1'b1; f.kind = K_RPAREN; end
            CH_LBRACE:  begin f.emit = 1'b1; f.kind = K_LBRACE; end
            CH_RBRACE:  begin f.emit = 1'b1; f.kind = K_RBRACE; end
            CH_COMMA:   begin f.emit = 1'b1; f.kind = K_COMMA; end
            CH_DOT:     begin f.emit = 1'b1; f.kind = K_DOT; end
            CH_MINUS:   begin f.emit = 1'b1; f.kind = K_MINUS; end
            CH_PLUS:    begin f.emit = 1'b1; f.kind = K_PLUS; end
            CH_SEMI:    begin f.emit = 1'b1; f.kind = K_SEMI; end
            CH_STAR:    begin f.emit = 1'b1; f.kind = K_STAR; end
            CH_BANG:    begin f.mode = M_OP; f.op = OP_BANG; end
            CH_EQUAL:   begin f.mode = M_OP; f.op = OP_EQUAL; end
            CH_GREATER: begin f.mode = M_OP; f.op = OP_GREATER; end
            CH_LESS:    begin f.mode = M_OP; f.op = OP_LESS; end
            CH_SLASH:   f.mode = M_SLASH;
            CH_QUOTE:   f.mode = M_STRING;
            CH_NEWLINE: f.newline = 1'b1;
            default: begin
                if (is_digit(c)) begin
                    f.mode = M_INT;
                end else if (is_letter(c)) begin
                    f.mode   = M_IDENT;
                    f.letter = 1'b1;
                end
            end
        endcase
        return f;
    endfunction

endpackage

>>> rtl/core/slt_stream_if.sv
// valid/ready channel carrying one payload per transfer
interface slt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/slt_core.sv
module slt_core
    import slt_pkg::*;
#(
    parameter int POS_BITS  = 16,
    parameter int LINE_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_go,
    input  t_item   i_item,
    output t_bundle o_bundle
);

    localparam int PEXT = (POS_BITS > OUT_W) ? POS_BITS : OUT_W;
    localparam int LEXT = (LINE_BITS > OUT_W) ? LINE_BITS : OUT_W;

    // lexer state
    t_mode                r_mode,  n_mode,  b_mode;
    t_op                  r_op,    n_op,    b_op;
    logic [POS_BITS-1:0]  r_start, n_start, b_start;
    logic [POS_BITS-1:0]  r_pos,   n_pos,   b_pos;
    logic [LINE_BITS-1:0] r_line,  n_line,  b_line;
    logic [WORD_W-1:0]    r_word,  n_word,  b_word;
    logic [WLEN_W-1:0]    r_wlen,  n_wlen,  b_wlen;

    logic [7:0]          c;
    logic [POS_BITS-1:0] p;
    logic [POS_BITS-1:0] e;
    t_fresh              f;
    logic                do_fresh;
    logic                line_up;

    function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] sat_pos(input logic [POS_BITS-1:0] v);
        logic [PEXT-1:0] x;
        x = PEXT'(v);
        return (x > PEXT'(OUT_MAX)) ? OUT_MAX : x[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] sat_line(input logic [LINE_BITS-1:0] v);
        logic [LEXT-1:0] x;
        x = LEXT'(v);
        return (x > LEXT'(OUT_MAX)) ? OUT_MAX : x[OUT_W-1:0];
    endfunction

    function automatic t_tok_info mk_tok(input logic [KIND_W-1:0]    kind,
                                         input logic [POS_BITS-1:0]  s,
                                         input logic [POS_BITS-1:0]  en,
                                         input logic [LINE_BITS-1:0] ln);
        t_tok_info           t;
        logic [POS_BITS-1:0] len;
        len      = (en >= s) ? en - s : '0;
        t.kind   = kind;
        t.start  = sat_pos(s);
        t.length = sat_pos(len);
        t.line   = sat_line(ln);
        return t;
    endfunction

    function automatic logic [KIND_W-1:0] op_kind(input t_op op);
        return 6'd9 + {2'b00, op, 1'b0};
    endfunction

    assign c = i_item.char_byte;
    assign p = r_pos;
    assign e = pos_inc(r_pos);
    assign f = fresh_scan(c);

    // state after the byte, before any end flush
    always_comb begin
        b_mode   = r_mode;
        b_op     = r_op;
        b_start  = r_start;
        b_pos    = r_pos;
        b_line   = r_line;
        b_word   = r_word;
        b_wlen   = r_wlen;
        do_fresh = 1'b0;
        line_up  = 1'b0;
        if (i_item.byte_valid) begin
            b_pos = e;
            unique case (r_mode)
                M_OP: begin
                    b_op = OP_NONE;
                    if (c == CH_EQUAL) begin
                        b_mode = M_IDLE;
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == CH_SLASH) begin
                        b_mode = M_COMMENT;
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (c == CH_NEWLINE) begin
                        line_up = 1'b1;
                        b_mode  = M_IDLE;
                    end
                end
                M_STRING: begin
                    if (c == CH_QUOTE) begin
                        b_mode = M_IDLE;
                    end else if (c == CH_NEWLINE) begin
                        line_up = 1'b1;
                    end
                end
                M_INT: begin
                    if (c == CH_DOT) begin
                        // the word buffer keeps the dot offset
                        b_mode                = M_NUMDOT;
                        b_word                = '0;
                        b_word[POS_BITS-1:0]  = r_pos;
                    end else if (!is_digit(c)) begin
                        do_fresh = 1'b1;
                    end
                end
                M_NUMDOT: begin
                    b_word = '0;
                    if (is_digit(c)) begin
                        b_mode = M_FRAC;
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (!is_digit(c)) begin
                        do_fresh = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_letter(c) || is_digit(c)) begin
                        b_word = {r_word[WORD_W-9:0], c};
                        if (r_wlen != WLEN_MAX) begin
                            b_wlen = r_wlen + 1'b1;
                        end
                    end else begin
                        do_fresh = 1'b1;
                    end
                end
                default: do_fresh = 1'b1;
            endcase
            // byte scanned with no lexeme open
            if (do_fresh) begin
                b_mode  = f.mode;
                b_start = r_pos;
                if (f.op != OP_NONE) begin
                    b_op = f.op;
                end
                if (f.newline) begin
                    line_up = 1'b1;
                end
                if (f.letter) begin
                    b_word = {{(WORD_W-8){1'b0}}, c};
                    b_wlen = WLEN_W'(1);
                end
            end
            if (line_up && (r_line != '1)) begin
                b_line = r_line + 1'b1;
            end
        end
    end

    // end of source returns everything to reset
    always_comb begin
        if (i_item.end_of_source) begin
            n_mode  = M_IDLE;
            n_op    = OP_NONE;
            n_start = '0;
            n_pos   = '0;
            n_line  = '0;
            n_word  = '0;
            n_wlen  = '0;
        end else begin
            n_mode  = b_mode;
            n_op    = b_op;
            n_start = b_start;
            n_pos   = b_pos;
            n_line  = b_line;
            n_word  = b_word;
            n_wlen  = b_wlen;
        end
    end

    // tokens of this item: byte phase, fresh scan, then flush
    always_comb begin
        logic [CNT_W-1:0]        cnt;
        t_tok_info [MAX_TOK-1:0] tok;
        logic [POS_BITS-1:0]     dot;
        cnt = '0;
        tok = '0;
        dot = r_word[POS_BITS-1:0];
        if (i_item.byte_valid) begin
            unique case (r_mode)
                M_OP: begin
                    if (c == CH_EQUAL) begin
                        tok[cnt[1:0]] = mk_tok(op_kind(r_op) + 1'b1, r_start, e, r_line);
                    end else begin
                        tok[cnt[1:0]] = mk_tok(op_kind(r_op), r_start, p, r_line);
                    end
                    cnt = cnt + 1'b1;
                end
                M_SLASH: begin
                    if (c != CH_SLASH) begin
                        tok[cnt[1:0]] = mk_tok(K_SLASH, r_start, p, r_line);
                        cnt = cnt + 1'b1;
                    end
                end
                M_STRING: begin
                    if (c == CH_QUOTE) begin
                        tok[cnt[1:0]] = mk_tok(K_STRING, r_start, e, r_line);
                        cnt = cnt + 1'b1;
                    end
                end
                M_INT, M_FRAC: begin
                    if (!is_digit(c) && !((r_mode == M_INT) && (c == CH_DOT))) begin
                        tok[cnt[1:0]] = mk_tok(K_NUMBER, r_start, p, r_line);
                        cnt = cnt + 1'b1;
                    end
                end
                M_NUMDOT: begin
                    // number then a dot that has no digit after it
                    if (!is_digit(c)) begin
                        tok[cnt[1:0]] = mk_tok(K_NUMBER, r_start, dot, r_line);
                        cnt = cnt + 1'b1;
                        tok[cnt[1:0]] = mk_tok(K_DOT, dot, pos_inc(dot), r_line);
                        cnt = cnt + 1'b1;
                    end
                end
                M_IDENT: begin
                    if (!(is_letter(c) || is_digit(c))) begin
                        tok[cnt[1:0]] = mk_tok(word_kind(r_word, r_wlen), r_start, p, r_line);
                        cnt = cnt + 1'b1;
                    end
                end
                default: ;
            endcase
            if (do_fresh && f.emit) begin
                tok[cnt[1:0]] = mk_tok(f.kind, p, e, r_line);
                cnt = cnt + 1'b1;
            end
        end
        if (i_item.end_of_source) begin
            dot = b_word[POS_BITS-1:0];
            unique case (b_mode)
                M_OP: begin
                    tok[cnt[1:0]] = mk_tok(op_kind(b_op), b_start, b_pos, b_line);
                    cnt = cnt + 1'b1;
                end
                M_SLASH: begin
                    tok[cnt[1:0]] = mk_tok(K_SLASH, b_start, b_pos, b_line);
                    cnt = cnt + 1'b1;
                end
                M_INT, M_FRAC: begin
                    tok[cnt[1:0]] = mk_tok(K_NUMBER, b_start, b_pos, b_line);
                    cnt = cnt + 1'b1;
                end
                M_NUMDOT: begin
                    tok[cnt[1:0]] = mk_tok(K_NUMBER, b_start, dot, b_line);
                    cnt = cnt + 1'b1;
                    tok[cnt[1:0]] = mk_tok(K_DOT, dot, pos_inc(dot), b_line);
                    cnt = cnt + 1'b1;
                end
                M_IDENT: begin
                    tok[cnt[1:0]] = mk_tok(word_kind(b_word, b_wlen), b_start, b_pos, b_line);
                    cnt = cnt + 1'b1;
                end
                default: ;
            endcase
            tok[cnt[1:0]] = mk_tok(K_END, b_pos, b_pos, b_line);
            cnt = cnt + 1'b1;
        end
        o_bundle.count = cnt;
        o_bundle.tok   = tok;
    end

    // state registers advance once per consumed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_op    <= OP_NONE;
            r_start <= '0;
            r_pos   <= '0;
            r_line  <= '0;
            r_word  <= '0;
            r_wlen  <= '0;
        end else if (i_go) begin
            r_mode  <= n_mode;
            r_op    <= n_op;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_word  <= n_word;
            r_wlen  <= n_wlen;
        end
    end

endmodule

>>> rtl/core/slt_outq.sv
module slt_outq
    import slt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_bundle       i_bundle,
    output logic          o_can_load,
    slt_stream_if.source  o_token
);

    t_tok_info [MAX_TOK-1:0] r_tok;
    logic [CNT_W-1:0]        r_left;
    logic [1:0]              r_idx;
    t_tok_info               cur;
    logic                    xfer;

    // present the current token of the group
    assign cur                       = r_tok[r_idx];
    assign o_token.valid             = (r_left != '0);
    assign o_token.data.token_kind   = cur.kind;
    assign o_token.data.token_start  = cur.start;
    assign o_token.data.token_length = cur.length;
    assign o_token.data.token_line   = cur.line;
    assign o_token.data.last_of_run  = (r_left == CNT_W'(1));

    assign xfer       = o_token.valid && o_token.ready;
    assign o_can_load = (r_left == '0) || ((r_left == CNT_W'(1)) && o_token.ready);

    // group payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= i_bundle.tok;
        end
    end

    // group count and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_left <= i_bundle.count;
            r_idx  <= '0;
        end else if (xfer) begin
            r_left <= r_left - 1'b1;
            r_idx  <= r_idx + 1'b1;
        end
    end

endmodule

>>> rtl/core/script_lexer_tokenizer.sv
// streaming tokenizer: source bytes in, tokens out
// i_item carries one source byte per transfer (byte_valid low for a flush-only
// item) and end_of_source on the item that closes the text
// o_token carries kind, start offset, length, line and last_of_run, which marks
// the last token caused by one input item
// an item is registered at its transfer; once the output group register can
// take it, the lexer state and the token group for the item are worked out
// and loaded into that register, which then offers the group's first token
// an item that causes n tokens holds the group register until all n are out
// (at most 4); items that cause one token or none stream at one per cycle
// while the receiver is ready, as the group register drains one per transfer
// the end item flushes a pending token, adds the end token and returns
// positions, line count and mode to their reset values
// reset clears the lexer state and drops any item or token in flight
// when the receiver stalls, the offered token holds and the input side stops
// after at most one more item, which waits in the input register
module script_lexer_tokenizer
    import slt_pkg::*;
#(
    parameter int POS_BITS  = 16,
    parameter int LINE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slt_stream_if.sink   i_item,
    slt_stream_if.source o_token
);

    logic    r_in_valid;
    t_item   r_item;
    logic    can_load;
    logic    go;
    t_bundle bundle;

    // input register
    assign go           = r_in_valid && can_load;
    assign i_item.ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item <= i_item.data;
        end
    end

    // lexer state and token generation
    slt_core #(
        .POS_BITS  (POS_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (r_item),
        .o_bundle (bundle)
    );

    // token group register and output serializer
    slt_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (go),
        .i_bundle   (bundle),
        .o_can_load (can_load),
        .o_token    (o_token)
    );

endmodule

>>> rtl/core/slt_checker.sv
`include "script_lexer_tokenizer_macros.svh"

module slt_checker
    import slt_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_valid,
    input logic   i_ready,
    input t_token i_data
);

    // a stalled token stays offered and unchanged
    `SLT_ASSERT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready |=> i_valid && $stable(i_data), "token changed while stalled")

    // nothing is offered right after reset
    `SLT_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_valid, "token offered after reset")

    // the end token closes its run and has no length
    `SLT_ASSERT(a_end_last, i_clk, i_rst_n, i_valid && (i_data.token_kind == K_END) |-> i_data.last_of_run && (i_data.token_length == '0), "bad end token")

    // kinds stay within the defined codes
    `SLT_ASSERT(a_kind_range, i_clk, i_rst_n, i_valid |-> (i_data.token_kind <= K_END), "token kind out of range")

endmodule

bind script_lexer_tokenizer slt_checker u_slt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_token.valid),
    .i_ready (o_token.ready),
    .i_data  (o_token.data)
);
